>>> design/ofhr_pkg.sv
// Shared widths, command codes, descriptor and result types of the frame history ring.
package ofhr_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W  = 7;
    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 14;
    localparam int TIME_W   = 63;
    localparam int SEQ_W    = 31;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        logic [TIME_W-1:0]   cap_time;
        logic [SEQ_W-1:0]    seq;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               has_frame;
        entry_t             entry;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

endpackage

>>> design/ofhr_if.sv
// Request and result channel interfaces of the frame history ring.
interface ofhr_cmd_if
    import ofhr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] frame_handle;
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
    logic [TIME_W-1:0]   capture_time;
    logic [SEQ_W-1:0]    sequence_number;

    modport source (
        output valid, cmd, frame_handle, frame_width, frame_height, capture_time,
               sequence_number,
        input  ready
    );
    modport sink (
        input  valid, cmd, frame_handle, frame_width, frame_height, capture_time,
               sequence_number,
        output ready
    );
endinterface

interface ofhr_res_if
    import ofhr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                has_frame;
    logic [HANDLE_W-1:0] out_handle;
    logic [SIZE_W-1:0]   out_width;
    logic [SIZE_W-1:0]   out_height;
    logic [TIME_W-1:0]   out_time;
    logic [SEQ_W-1:0]    out_sequence;
    logic [COUNT_W-1:0]  frame_count;
    logic                last;

    modport source (
        output valid, has_frame, out_handle, out_width, out_height, out_time,
               out_sequence, frame_count, last,
        input  ready
    );
    modport sink (
        input  valid, has_frame, out_handle, out_width, out_height, out_time,
               out_sequence, frame_count, last,
        output ready
    );
endinterface

>>> design/ofhr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ofhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> design/overwriting_frame_history_ring_core.sv
// Top level of the overwriting frame history ring: control, ring pointers and output register.
//
// Keeps the last DEPTH frame descriptors (handle, width, height, capture time,
// sequence number) in one synchronous RAM written as a ring that overwrites the
// oldest entry. Commands arrive as transfers on the request channel: add (one
// RAM write, pointer advance), dump (walk the held entries oldest first, skip
// zero handles), clear (reset pointer and wrapped flag; entries are not erased).
// Add, clear and the unused code each produce one status transfer with last set;
// a new request is taken as soon as the output register is free or being
// drained. During a dump the single RAM read port walks one entry per cycle
// while the result side does not stall, and one found entry is held back so
// that last can be marked on the final nonzero descriptor. A dump that finds
// nothing gives one empty transfer.
// No request is accepted while a dump is walking. Every result carries the
// current frame count (DEPTH once wrapped, else the write pointer).
module overwriting_frame_history_ring_core
    import ofhr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ofhr_cmd_if.sink   request,
    ofhr_res_if.source result
);

    state_t             state_reg,  state_next;
    logic [ADDR_W-1:0]  wp_reg,     wp_next;
    logic               wrap_reg,   wrap_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg,    out_next;
    logic [ADDR_W-1:0]  addr_reg,   addr_next;
    logic [COUNT_W-1:0] iss_reg,    iss_next;
    logic [COUNT_W-1:0] n_reg,      n_next;
    logic               rdv_reg,    rdv_next;
    logic               pend_valid_reg, pend_valid_next;
    entry_t             pend_reg,   pend_next;

    logic               ram_we;
    logic               ram_re;
    entry_t             wr_entry;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    logic [COUNT_W-1:0] held;
    logic [ADDR_W-1:0]  wp_inc;
    logic [ADDR_W-1:0]  addr_inc;
    logic               out_free;
    logic               accept;
    logic               rd_hit;
    logic               consume;
    logic               can_issue;

    function automatic result_t make_result(input logic has, input entry_t e,
                                            input logic [COUNT_W-1:0] cnt,
                                            input logic lst);
        result_t r;
        r.has_frame = has;
        r.entry     = has ? e : '0;
        r.count     = cnt;
        r.last      = lst;
        return r;
    endfunction

    // Frames held: full depth once the pointer has wrapped.
    assign held     = wrap_reg ? COUNT_W'(DEPTH) : COUNT_W'(wp_reg);
    assign wp_inc   = (wp_reg == ADDR_W'(DEPTH - 1)) ? '0 : wp_reg + ADDR_W'(1);
    assign addr_inc = (addr_reg == ADDR_W'(DEPTH - 1)) ? '0 : addr_reg + ADDR_W'(1);

    assign out_free      = !out_valid_reg || result.ready;
    assign request.ready = (state_reg == ST_IDLE) && out_free;
    assign accept        = request.valid && request.ready;

    assign wr_entry.handle   = request.frame_handle;
    assign wr_entry.width    = request.frame_width;
    assign wr_entry.height   = request.frame_height;
    assign wr_entry.cap_time = request.capture_time;
    assign wr_entry.seq      = request.sequence_number;

    assign rd_entry = entry_t'(ram_rdata);

    // A nonzero entry read while another is held back needs the output slot.
    assign rd_hit    = rdv_reg && (rd_entry.handle != '0);
    assign consume   = rdv_reg && (!(rd_hit && pend_valid_reg) || out_free);
    assign can_issue = (state_reg == ST_DUMP) && (iss_reg != n_reg) && (!rdv_reg || consume);

    assign ram_we = accept && (request.cmd == CMD_ADD);
    assign ram_re = can_issue;

    ofhr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        wrap_next       = wrap_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        addr_next       = addr_reg;
        iss_next        = iss_reg;
        n_next          = n_reg;
        rdv_next        = rdv_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        // Drop the output item once the sink takes it.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    case (request.cmd)
                        CMD_ADD:
                        begin
                            wp_next = wp_inc;
                            if (wp_inc == '0)
                            begin
                                wrap_next = 1'b1;
                            end
                            out_next = make_result(1'b0, '0,
                                (wrap_reg || (wp_inc == '0)) ? COUNT_W'(DEPTH)
                                                             : COUNT_W'(wp_inc),
                                1'b1);
                        end
                        CMD_CLEAR:
                        begin
                            wp_next   = '0;
                            wrap_next = 1'b0;
                            out_next  = make_result(1'b0, '0, '0, 1'b1);
                        end
                        CMD_DUMP:
                        begin
                            if (held == '0)
                            begin
                                out_next = make_result(1'b0, '0, held, 1'b1);
                            end
                            else
                            begin
                                // Start the walk at the oldest entry.
                                out_valid_next  = out_valid_reg && !result.ready;
                                state_next      = ST_DUMP;
                                addr_next       = wrap_reg ? wp_reg : '0;
                                iss_next        = '0;
                                n_next          = held;
                                rdv_next        = 1'b0;
                                pend_valid_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            out_next = make_result(1'b0, '0, held, 1'b1);
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                // Emit the held entry when a newer nonzero one replaces it.
                if (rd_hit && pend_valid_reg && out_free)
                begin
                    out_next       = make_result(1'b1, pend_reg, held, 1'b0);
                    out_valid_next = 1'b1;
                end
                if (consume && rd_hit)
                begin
                    pend_next       = rd_entry;
                    pend_valid_next = 1'b1;
                end
                if (can_issue)
                begin
                    addr_next = addr_inc;
                    iss_next  = iss_reg + COUNT_W'(1);
                    rdv_next  = 1'b1;
                end
                else if (consume)
                begin
                    rdv_next = 1'b0;
                end
                // Walk done: hand out the final descriptor, or an empty result.
                if (!rdv_reg && (iss_reg == n_reg) && out_free)
                begin
                    out_next       = make_result(pend_valid_reg, pend_reg, held, 1'b1);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            wrap_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            addr_reg       <= '0;
            iss_reg        <= '0;
            n_reg          <= '0;
            rdv_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            wrap_reg       <= wrap_next;
            out_valid_reg  <= out_valid_next;
            addr_reg       <= addr_next;
            iss_reg        <= iss_next;
            n_reg          <= n_next;
            rdv_reg        <= rdv_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.has_frame    = out_reg.has_frame;
    assign result.out_handle   = out_reg.entry.handle;
    assign result.out_width    = out_reg.entry.width;
    assign result.out_height   = out_reg.entry.height;
    assign result.out_time     = out_reg.entry.cap_time;
    assign result.out_sequence = out_reg.entry.seq;
    assign result.frame_count  = out_reg.count;
    assign result.last         = out_reg.last;

endmodule

>>> test/tb_overwriting_frame_history_ring_core.sv
// Testbench of the overwriting frame history ring: request driver, ring predictor, result checker.
`timescale 1ns / 1ps

module tb_overwriting_frame_history_ring_core
    import ofhr_pkg::*;
();

    // The block has no name for the spare command code; it must act as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int HALF_PERIOD  = 1;
    // Quiet cycles after the last expected transfer: a full dump walk and then some.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    // Hard stop in ns, far beyond the slowest legal run of this stimulus.
    localparam int WATCHDOG_NS  = 400000;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        entry_t           desc;
    } frame_req_t;

    logic clk;
    logic rst_n;

    ofhr_cmd_if req_bus();
    ofhr_res_if res_bus();

    overwriting_frame_history_ring_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(req_bus),
        .result (res_bus)
    );

    // Shadow copy of the ring: entries, write pointer and wrapped flag.
    entry_t      ring_mem [DEPTH];
    int unsigned ring_wp;
    bit          ring_wrapped;

    // Results the block still owes, oldest first.
    result_t pending_results [$];

    // Idle percentages of the request side and the result side.
    int send_idle_pct;
    int recv_idle_pct;

    int fail_count;
    int results_checked;
    int frames_seen;
    int cmd_seen [4];

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Frames held right now: the whole ring once it has wrapped, else the pointer.
    function automatic logic [COUNT_W-1:0] held_frames();
        return ring_wrapped ? COUNT_W'(DEPTH) : COUNT_W'(ring_wp);
    endfunction

    // Update the shadow ring with one accepted request and queue what it must produce.
    function automatic void predict_ring_response(frame_req_t req);
        result_t     rsp;
        int unsigned held;
        int unsigned first;
        int unsigned slot;
        int unsigned live;
        int unsigned emitted;

        rsp = '0;
        case (req.cmd)
            CMD_ADD:
            begin
                ring_mem[ring_wp] = req.desc;
                ring_wp = (ring_wp + 1) % DEPTH;
                if (ring_wp == 0)
                begin
                    ring_wrapped = 1'b1;
                end
            end
            CMD_DUMP:
            begin
                // Walk oldest first: from the pointer once wrapped, else from slot zero.
                held  = ring_wrapped ? DEPTH : ring_wp;
                first = ring_wrapped ? ring_wp : 0;
                live  = 0;
                for (int i = 0; i < held; i++)
                begin
                    if (ring_mem[(first + i) % DEPTH].handle != '0)
                    begin
                        live++;
                    end
                end
                if (live != 0)
                begin
                    emitted = 0;
                    for (int i = 0; i < held; i++)
                    begin
                        slot = (first + i) % DEPTH;
                        // Skip entries that carry no frame handle.
                        if (ring_mem[slot].handle != '0)
                        begin
                            emitted++;
                            rsp.has_frame = 1'b1;
                            rsp.entry     = ring_mem[slot];
                            rsp.count     = held_frames();
                            rsp.last      = (emitted == live);
                            pending_results.insert(pending_results.size(), rsp);
                        end
                    end
                    return;
                end
            end
            CMD_CLEAR:
            begin
                // Drop the pointer and flag only; stored entries stay but become unreachable.
                ring_wp      = 0;
                ring_wrapped = 1'b0;
            end
            default:
            begin
            end
        endcase
        // Add, clear, the spare code and an empty dump: one status transfer.
        rsp       = '0;
        rsp.count = held_frames();
        rsp.last  = 1'b1;
        pending_results.insert(pending_results.size(), rsp);
    endfunction

    function automatic frame_req_t make_req(logic [CMD_W-1:0] cmd, entry_t desc);
        frame_req_t req;
        req.cmd  = cmd;
        req.desc = desc;
        return req;
    endfunction

    // Random descriptor; one in eight has no handle, one in sixteen an all-ones handle.
    function automatic entry_t random_frame();
        entry_t      desc;
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick < 2)
        begin
            desc.handle = '0;
        end
        else if (pick == 2)
        begin
            desc.handle = '1;
        end
        else
        begin
            desc.handle = $urandom;
        end
        desc.width    = SIZE_W'($urandom);
        desc.height   = SIZE_W'($urandom);
        desc.cap_time = TIME_W'({$urandom, $urandom});
        desc.seq      = SEQ_W'($urandom);
        return desc;
    endfunction

    // Drive one request transfer. Enter and leave at a falling edge; valid stays high on exit
    // so back-to-back requests keep it asserted, and an idle cycle lowers it.
    task automatic send_request(frame_req_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid           <= 1'b1;
        req_bus.cmd             <= req.cmd;
        req_bus.frame_handle    <= req.desc.handle;
        req_bus.frame_width     <= req.desc.width;
        req_bus.frame_height    <= req.desc.height;
        req_bus.capture_time    <= req.desc.cap_time;
        req_bus.sequence_number <= req.desc.seq;
        // Hold the request until the block takes it.
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        predict_ring_response(req);
        cmd_seen[req.cmd]++;
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Randomize result-side backpressure at each falling edge.
    always @(negedge clk)
    begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: has_frame %0b handle %0h last %0b",
                       res_bus.has_frame, res_bus.out_handle, res_bus.last);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("has_frame", want.has_frame, res_bus.has_frame);
                check_field("out_handle", want.entry.handle, res_bus.out_handle);
                check_field("out_width", want.entry.width, res_bus.out_width);
                check_field("out_height", want.entry.height, res_bus.out_height);
                check_field("out_time", want.entry.cap_time, res_bus.out_time);
                check_field("out_sequence", want.entry.seq, res_bus.out_sequence);
                check_field("frame_count", want.count, res_bus.frame_count);
                check_field("last", want.last, res_bus.last);
                results_checked++;
                if (want.has_frame)
                begin
                    frames_seen++;
                end
            end
        end
    end

    // Corners: empty store, spare code, extreme fields, zero handles, clear.
    task automatic test_directed_corners();
        entry_t full_desc;
        entry_t zero_handle_desc;
        entry_t min_desc;

        full_desc               = '1;
        zero_handle_desc        = '1;
        zero_handle_desc.handle = '0;
        min_desc                = '0;
        min_desc.handle         = 32'd1;

        // Dump on an empty store gives one empty transfer with count zero.
        send_request(make_req(CMD_DUMP, '0));
        send_request(make_req(CMD_UNUSED, '0));
        send_request(make_req(CMD_CLEAR, '0));
        send_request(make_req(CMD_ADD, full_desc));
        // Store and count a zero handle, but expect the dump to skip it.
        send_request(make_req(CMD_ADD, zero_handle_desc));
        send_request(make_req(CMD_ADD, min_desc));
        send_request(make_req(CMD_DUMP, '0));
        // Spare code with busy fields must leave the ring alone.
        send_request(make_req(CMD_UNUSED, full_desc));
        send_request(make_req(CMD_DUMP, full_desc));
        // Only zero handles held: expect an empty dump that still reports two frames.
        send_request(make_req(CMD_CLEAR, full_desc));
        send_request(make_req(CMD_ADD, zero_handle_desc));
        send_request(make_req(CMD_ADD, zero_handle_desc));
        send_request(make_req(CMD_DUMP, '0));
        // Clear hides the old entries again.
        send_request(make_req(CMD_CLEAR, '0));
        send_request(make_req(CMD_DUMP, '0));
    endtask

    // Fill past the ring size: dump just past half full, exactly full, and after overwriting.
    task automatic test_ring_wrap();
        send_request(make_req(CMD_CLEAR, random_frame()));
        for (int i = 0; i < DEPTH + 6; i++)
        begin
            send_request(make_req(CMD_ADD, random_frame()));
            if (i == DEPTH / 2 || i == DEPTH - 1 || i == DEPTH + 5)
            begin
                send_request(make_req(CMD_DUMP, random_frame()));
            end
        end
    endtask

    // Mostly adds with random content; dumps, clears and the spare code mixed in as noise.
    task automatic test_random_mix(int num_items);
        int unsigned      pick;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < num_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                cmd = CMD_ADD;
            end
            else if (pick < 82)
            begin
                cmd = CMD_DUMP;
            end
            else if (pick < 88)
            begin
                cmd = CMD_CLEAR;
            end
            else
            begin
                cmd = CMD_UNUSED;
            end
            send_request(make_req(cmd, random_frame()));
        end
    endtask

    initial
    begin
        fail_count      = 0;
        results_checked = 0;
        frames_seen     = 0;
        foreach (cmd_seen[i])
        begin
            cmd_seen[i] = 0;
        end
        ring_wp       = 0;
        ring_wrapped  = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 54;

        // Drive every input to a known value before the first edge.
        rst_n                   = 1'b0;
        req_bus.valid           = 1'b0;
        req_bus.cmd             = CMD_ADD;
        req_bus.frame_handle    = '0;
        req_bus.frame_width     = '0;
        req_bus.frame_height    = '0;
        req_bus.capture_time    = '0;
        req_bus.sequence_number = '0;
        res_bus.ready           = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles lightly, receiver heavily.
        test_directed_corners();
        test_ring_wrap();

        // Swap the pressure: sender idles heavily, receiver lightly.
        send_idle_pct = 54;
        recv_idle_pct = 22;
        test_random_mix(35);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(35);

        req_bus.valid <= 1'b0;

        // Drain what is owed, then watch for stray transfers.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d adds, %0d dumps, %0d clears and %0d spare-code requests.",
                 cmd_seen[CMD_ADD], cmd_seen[CMD_DUMP], cmd_seen[CMD_CLEAR],
                 cmd_seen[CMD_UNUSED]);
        $display("Checked %0d result transfers, %0d of them carrying stored frames.",
                 results_checked, frames_seen);
        if (fail_count == 0)
        begin
            $display("overwriting_frame_history_ring_core verification clean");
        end
        else
        begin
            $display("overwriting_frame_history_ring_core verification failed");
        end
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #WATCHDOG_NS;
        $display("overwriting_frame_history_ring_core verification failed");
        $finish;
    end

endmodule
